>>> rtl/fpt_pkg.sv
// ----------------------------------------------------------------------------
// fpt_pkg
// shared types and constants of the frustum point test unit
// ----------------------------------------------------------------------------
package fpt_pkg;

    localparam int unsigned DATA_W      = 32;   // q16.16 values
    localparam int unsigned FRAC_W      = 16;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned MAT_N       = 16;
    localparam int unsigned ROWS        = 4;
    localparam int unsigned COLS        = 4;
    localparam int unsigned AXES        = 3;
    localparam int unsigned PROD_W      = 2 * DATA_W;
    localparam int unsigned SUM_W       = PROD_W + 2;  // three products plus offset term
    localparam int unsigned DIST_W      = SUM_W + 1;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned CNT_W       = QPTR_W + 1;
    localparam int unsigned IN_TDATA_W  = 136;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_TEST  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                      op;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] point_z;
        logic                     skip_vertical;
    } item_t;

endpackage

>>> rtl/fpt_front.sv
// ----------------------------------------------------------------------------
// fpt_front
// input side: takes stream transactions, decodes the kind and queues them
// ----------------------------------------------------------------------------
module fpt_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [fpt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic [fpt_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                               q_valid,
    input  logic                               q_pop,
    output fpt_pkg::item_t                     q_item
);

    fpt_pkg::item_t                  queue_mem [fpt_pkg::QUEUE_DEPTH];
    logic [fpt_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [fpt_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [fpt_pkg::CNT_W-1:0]       count_reg, count_next;
    fpt_pkg::item_t                  in_item;
    logic                            push;
    logic                            pop;

    always_comb
    begin
        in_item.op            = fpt_pkg::op_t'(s_axis_tuser[0]);
        in_item.skip_vertical = s_axis_tuser[1];
        in_item.entry_index   = s_axis_tdata[3:0];
        in_item.entry_value   = s_axis_tdata[35:4];
        in_item.point_x       = s_axis_tdata[67:36];
        in_item.point_y       = s_axis_tdata[99:68];
        in_item.point_z       = s_axis_tdata[131:100];
    end

    assign s_axis_tready = (count_reg != fpt_pkg::CNT_W'(fpt_pkg::QUEUE_DEPTH));
    assign q_valid       = (count_reg != '0);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_pop && q_valid;
    assign q_item        = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + fpt_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + fpt_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + fpt_pkg::CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - fpt_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/fpt_back.sv
// ----------------------------------------------------------------------------
// fpt_back
// execution side: matrix store, clip term pipeline and plane sign checks
// ----------------------------------------------------------------------------
module fpt_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_pop,
    input  fpt_pkg::item_t                     q_item,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fpt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic signed [fpt_pkg::DATA_W-1:0]  mat_reg   [fpt_pkg::MAT_N];
    logic signed [fpt_pkg::DATA_W-1:0]  pt        [fpt_pkg::AXES];
    logic signed [fpt_pkg::PROD_W-1:0]  prod_next [fpt_pkg::ROWS][fpt_pkg::AXES];
    logic signed [fpt_pkg::PROD_W-1:0]  prod_reg  [fpt_pkg::ROWS][fpt_pkg::AXES];
    logic signed [fpt_pkg::DATA_W-1:0]  ofs_reg   [fpt_pkg::ROWS];
    logic signed [fpt_pkg::SUM_W-1:0]   sum_next  [fpt_pkg::ROWS];
    logic signed [fpt_pkg::SUM_W-1:0]   sum_reg   [fpt_pkg::ROWS];
    logic signed [fpt_pkg::DIST_W-1:0]  dist_pos  [fpt_pkg::AXES];
    logic signed [fpt_pkg::DIST_W-1:0]  dist_neg  [fpt_pkg::AXES];
    logic [fpt_pkg::AXES-1:0]           plane_ok;
    logic                               a_valid_reg, b_valid_reg, out_valid_reg;
    logic                               a_skip_reg, b_skip_reg;
    logic                               inside_next, inside_reg;
    logic                               advance;
    logic                               take;

    // whole pipeline moves together, held only while the result waits
    assign advance = !out_valid_reg || m_axis_tready;
    assign q_pop   = advance;
    assign take    = advance && q_valid;

    assign pt[0] = q_item.point_x;
    assign pt[1] = q_item.point_y;
    assign pt[2] = q_item.point_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fpt_pkg::MAT_N; i++)
            begin
                mat_reg[i] <= '0;
            end
        end
        else if (take && (q_item.op == fpt_pkg::OP_WRITE))
        begin
            mat_reg[q_item.entry_index] <= q_item.entry_value;
        end
    end

    // stage a: twelve products, column three kept as the offset term
    for (genvar r = 0; r < fpt_pkg::ROWS; r++)
    begin : g_row
        for (genvar j = 0; j < fpt_pkg::AXES; j++)
        begin : g_axis
            assign prod_next[r][j] = mat_reg[r*fpt_pkg::COLS+j] * pt[j];
        end

        // stage b: row dot product with (x, y, z, 1)
        assign sum_next[r] = fpt_pkg::SUM_W'(prod_reg[r][0])
                           + fpt_pkg::SUM_W'(prod_reg[r][1])
                           + fpt_pkg::SUM_W'(prod_reg[r][2])
                           + (fpt_pkg::SUM_W'(ofs_reg[r]) <<< fpt_pkg::FRAC_W);
    end

    // stage c: plane distances w + c and w - c, only the sign matters
    for (genvar r = 0; r < fpt_pkg::AXES; r++)
    begin : g_plane
        assign dist_pos[r] = fpt_pkg::DIST_W'(sum_reg[fpt_pkg::ROWS-1])
                           + fpt_pkg::DIST_W'(sum_reg[r]);
        assign dist_neg[r] = fpt_pkg::DIST_W'(sum_reg[fpt_pkg::ROWS-1])
                           - fpt_pkg::DIST_W'(sum_reg[r]);
        assign plane_ok[r] = !dist_pos[r][fpt_pkg::DIST_W-1]
                           && !dist_neg[r][fpt_pkg::DIST_W-1];
    end

    assign inside_next = plane_ok[0] && (plane_ok[1] || b_skip_reg) && plane_ok[2];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int r = 0; r < fpt_pkg::ROWS; r++)
            begin
                for (int j = 0; j < fpt_pkg::AXES; j++)
                begin
                    prod_reg[r][j] <= prod_next[r][j];
                end
                ofs_reg[r] <= mat_reg[r*fpt_pkg::COLS+fpt_pkg::AXES];
                sum_reg[r] <= sum_next[r];
            end
            a_skip_reg <= q_item.skip_vertical;
            b_skip_reg <= a_skip_reg;
            inside_reg <= inside_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= q_valid && (q_item.op == fpt_pkg::OP_TEST);
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(fpt_pkg::OUT_TDATA_W-1){1'b0}}, inside_reg};

endmodule

>>> rtl/frustum_point_test_unit.sv
// ----------------------------------------------------------------------------
// frustum_point_test_unit
// view frustum point test against a stored 4x4 view-projection matrix
// ----------------------------------------------------------------------------
// input channel s_axis: tuser[0] selects the kind. a write transaction
// (tuser[0] = 0) loads one matrix entry, row*4 + column, and gives no result.
// a test transaction (tuser[0] = 1) carries a q16.16 point and gives one
// result on m_axis: tdata[0] is 1 when the point lies on the inner side of
// the left/right, top/bottom and near/far planes; tuser[1] drops the top and
// bottom planes from the test.
// throughput is one transaction per cycle on either kind. a test result
// goes from the queue read through the twelve 32x32 products and the row
// sums, then the plane signs into the output register. a write takes
// effect for every test accepted after it. reset clears the matrix to
// zero and empties the queue and the pipeline. when the receiver holds
// m_axis_tready low against a valid result, the result stays put and the
// pipeline stops; the 4-entry input queue keeps taking transactions until
// it is full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module frustum_point_test_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // entry_index, entry_value, point_x, point_y, point_z, zero fill
    input  logic [fpt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // op, skip_vertical
    input  logic [fpt_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // inside_res, zero fill
    output logic [fpt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    fpt_pkg::item_t q_item;
    logic           q_valid;
    logic           q_pop;

    fpt_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item)
    );

    fpt_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> rtl/fpt_checker.sv
// ----------------------------------------------------------------------------
// fpt_checker
// port level checks of the frustum point test unit
// ----------------------------------------------------------------------------
module fpt_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [fpt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic [fpt_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [fpt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // a waiting input transaction keeps its value
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && !s_axis_tready) |=>
            (s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser)))
        else $error("input changed while waiting");

    // only the inside bit may be set
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[fpt_pkg::OUT_TDATA_W-1:1] == '0))
        else $error("result fill bits not zero");

    // no result can come out of an empty pipeline right after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(!rst_n) || $past(!rst_n, 2)) |-> !m_axis_tvalid)
        else $error("result valid too soon after reset");

    // an empty queue after reset takes input at once
    a_reset_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind frustum_point_test_unit fpt_checker u_fpt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb_frustum_point_test_unit.sv
// ----------------------------------------------------------------------------
// tb_frustum_point_test_unit
// self-checking bench for the frustum point test unit
// ----------------------------------------------------------------------------
// loads view-projection matrices entry by entry and streams points against
// them. a local model of the matrix store and the six plane signs predicts
// the inside bit for every accepted test; results are checked in order while
// both stream sides are throttled at random in two of three pacing phases.
// ----------------------------------------------------------------------------
module tb_frustum_point_test_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int Q_ONE       = 65536;

    logic                               clk;
    logic                               rst_n         = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // entry_index, entry_value, point_x, point_y, point_z, zero fill
    logic [fpt_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;
    // op, skip_vertical
    logic [fpt_pkg::IN_TUSER_W-1:0]     s_axis_tuser  = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // inside_res, zero fill
    logic [fpt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;

    // local copy of the matrix store, row*4 + column
    logic signed [fpt_pkg::DATA_W-1:0]  view_proj [fpt_pkg::MAT_N];
    bit                                 inside_expect_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int writes_sent    = 0;
    int tests_sent     = 0;
    int inside_seen    = 0;
    int cycle_count    = 0;

    frustum_point_test_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, inside_expect_q.size());
        $display("frustum_point_test_unit verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // exact sign test of the x, y and z plane pairs; 96 bits hold any sum
    function automatic bit point_inside(input logic signed [fpt_pkg::DATA_W-1:0] px,
                                        input logic signed [fpt_pkg::DATA_W-1:0] py,
                                        input logic signed [fpt_pkg::DATA_W-1:0] pz,
                                        input bit skip_v);
        logic signed [95:0] coord [4];
        logic signed [95:0] w_coef;
        logic signed [95:0] r_coef;
        logic signed [95:0] plus_dist;
        logic signed [95:0] minus_dist;
        bit in_view;
        coord[0] = px;
        coord[1] = py;
        coord[2] = pz;
        coord[3] = 96'sd65536;
        in_view = 1'b1;
        for (int r = 0; r < 3; r++)
        begin
            if (r == 1 && skip_v)
                continue;
            plus_dist  = '0;
            minus_dist = '0;
            for (int j = 0; j < 4; j++)
            begin
                w_coef = view_proj[12 + j];
                r_coef = view_proj[r * 4 + j];
                plus_dist  = plus_dist  + (w_coef + r_coef) * coord[j];
                minus_dist = minus_dist + (w_coef - r_coef) * coord[j];
            end
            if (plus_dist[95] || minus_dist[95])
                in_view = 1'b0;
        end
        return in_view;
    endfunction

    task automatic send_item(input fpt_pkg::op_t                      op,
                             input logic [fpt_pkg::IDX_W-1:0]         idx,
                             input logic signed [fpt_pkg::DATA_W-1:0] value,
                             input logic signed [fpt_pkg::DATA_W-1:0] px,
                             input logic signed [fpt_pkg::DATA_W-1:0] py,
                             input logic signed [fpt_pkg::DATA_W-1:0] pz,
                             input bit                                skip_v);
        // each idle cycle is drawn on its own so the idle share matches the rate
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, pz, py, px, value, idx};
        s_axis_tuser  <= {skip_v, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (op == fpt_pkg::OP_WRITE)
        begin
            view_proj[idx] = value;
            writes_sent++;
        end
        else
        begin
            inside_expect_q.push_back(point_inside(px, py, pz, skip_v));
            tests_sent++;
        end
    endtask

    task automatic write_entry(input int idx, input logic signed [fpt_pkg::DATA_W-1:0] value);
        send_item(fpt_pkg::OP_WRITE, fpt_pkg::IDX_W'(idx), value, $urandom, $urandom, $urandom,
                  1'($urandom_range(0, 1)));
    endtask

    task automatic test_point(input logic signed [fpt_pkg::DATA_W-1:0] px,
                              input logic signed [fpt_pkg::DATA_W-1:0] py,
                              input logic signed [fpt_pkg::DATA_W-1:0] pz,
                              input bit skip_v);
        send_item(fpt_pkg::OP_TEST, fpt_pkg::IDX_W'($urandom_range(0, 15)), $urandom,
                  px, py, pz, skip_v);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (inside_expect_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [fpt_pkg::DATA_W-1:0] rand_span(input int half);
        return fpt_pkg::DATA_W'(int'($urandom_range(0, 2 * half)) - half);
    endfunction

    // all planes of a zero matrix sit at distance zero
    task automatic test_reset_matrix();
        test_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, 1'b0);
        test_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    endtask

    task automatic test_extreme_entries();
        write_entry(15, 32'sh7fff_ffff);
        write_entry(0, 32'sh8000_0000);
        test_point(32'sh0, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
        test_point(32'sh7fff_ffff, 32'sh0, 32'sh0, 1'b0);
        test_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    endtask

    // |cy| exceeds cw: only the top/bottom pair rejects the point
    task automatic test_skip_vertical();
        write_entry(0, 32'sh0);
        write_entry(15, Q_ONE);
        write_entry(5, Q_ONE);
        test_point(32'sh0, 2 * Q_ONE, 32'sh0, 1'b0);
        test_point(32'sh0, 2 * Q_ONE, 32'sh0, 1'b1);
        test_point(32'sh0, -2 * Q_ONE, 32'sh0, 1'b1);
        test_point(32'sh0, Q_ONE / 2, 32'sh0, 1'b0);
    endtask

    // distance exactly zero passes, one lsb beyond fails
    task automatic test_exact_boundary();
        write_entry(10, Q_ONE);
        test_point(32'sh0, 32'sh0, Q_ONE, 1'b0);
        test_point(32'sh0, 32'sh0, Q_ONE + 1, 1'b0);
    endtask

    // full matrix load followed by a burst of points against it
    task automatic test_random_frustums(input int sets, input int points, input bit drain_once);
        int start;
        bit wild;
        logic signed [fpt_pkg::DATA_W-1:0] value;
        for (int s = 0; s < sets; s++)
        begin
            start = $urandom_range(0, 15);
            wild  = ($urandom_range(0, 7) == 0);
            for (int k = 0; k < fpt_pkg::MAT_N; k++)
            begin
                int idx;
                idx = (start + k) % fpt_pkg::MAT_N;
                if (wild)
                    value = $urandom;
                else if (idx == 15)
                    value = fpt_pkg::DATA_W'($urandom_range(0, 8 * Q_ONE));
                else if (idx >= 12)
                    value = rand_span(Q_ONE / 4);
                else
                    value = rand_span(Q_ONE);
                write_entry(idx, value);
            end
            for (int p = 0; p < points; p++)
            begin
                if ($urandom_range(0, 9) == 0)
                    test_point($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
                else
                    test_point(rand_span(4 * Q_ONE), rand_span(4 * Q_ONE),
                               rand_span(4 * Q_ONE), 1'($urandom_range(0, 1)));
            end
            if (drain_once && s == sets / 2)
                wait_results_drained();
        end
    endtask

    task automatic test_random_noise(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_item($urandom_range(0, 1) ? fpt_pkg::OP_TEST : fpt_pkg::OP_WRITE,
                      fpt_pkg::IDX_W'($urandom_range(0, 15)),
                      $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    // result side: check each transaction, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (inside_expect_q.size() == 0)
                report_mismatch($sformatf("result %0d with none expected", m_axis_tdata[0]));
            else
            begin
                if (m_axis_tdata[0] !== inside_expect_q[0])
                    report_mismatch($sformatf("inside_res got %b expected %b",
                                              m_axis_tdata[0], inside_expect_q[0]));
                if (inside_expect_q[0])
                    inside_seen++;
                void'(inside_expect_q.pop_front());
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin
        for (int i = 0; i < fpt_pkg::MAT_N; i++)
            view_proj[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 15;
        recv_stall_pct = 80;
        test_reset_matrix();
        test_extreme_entries();
        test_skip_vertical();
        test_exact_boundary();
        test_random_frustums(6, 40, 1'b1);
        test_random_noise(40);

        send_idle_pct  = 80;
        recv_stall_pct = 15;
        test_random_frustums(6, 40, 1'b0);
        test_random_noise(40);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_frustums(6, 40, 1'b0);
        test_random_noise(40);

        wait_results_drained();
        repeat (LATENCY + 5) @(posedge clk);
        if (inside_expect_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", inside_expect_q.size()));

        $display("sent %0d matrix writes and %0d point tests, %0d judged inside",
                 writes_sent, tests_sent, inside_seen);
        $display("three pacing phases, %0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("frustum_point_test_unit verification clean");
        else
            $display("frustum_point_test_unit verification failed");
        $finish;
    end

endmodule
